// ----- src/ece_pkg.sv -----
// Shared types, codes and constants of the easing curve evaluator.
package ece_pkg;

  localparam int WORK_BITS = 30;
  localparam int WW        = 32;
  localparam int CUR_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = WORK_BITS + 1;
  localparam int DIV_CW    = 5;
  localparam int QUO_W     = WORK_BITS + 1;
  localparam int REM_W     = 34;

  localparam logic [WW-1:0] ONE_W  = 32'h4000_0000;
  localparam logic [WW-1:0] HALF_W = 32'h2000_0000;
  localparam logic [WW-1:0] TWO_W  = 32'h8000_0000;

  localparam logic [WW-1:0] SC1  = 32'd1686629713;
  localparam logic [WW-1:0] SC3  = 32'd693598668;
  localparam logic [WW-1:0] SC5  = 32'd85569306;
  localparam logic [WW-1:0] SC7  = 32'd5026995;
  localparam logic [WW-1:0] SC9  = 32'd172272;
  localparam logic [WW-1:0] SC11 = 32'd3864;
  localparam logic [2:0] SIN_LAST = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EASE_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_ORDER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_DECAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_DECAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_SCALE = 3'd5;

  localparam logic [1:0] KIND_LINEAR = 2'd0;
  localparam logic [1:0] KIND_SINE   = 2'd1;
  localparam logic [1:0] KIND_POLY   = 2'd2;
  localparam logic [1:0] KIND_BOUNCE = 2'd3;

  localparam logic [1:0] MODE_IN    = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_INOUT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_SIN_X2, S_SIN_X2W, S_SIN_M, S_SIN_MW, S_SIN_F, S_SIN_FW,
    S_POW_M, S_POW_W, S_B_INIT, S_B_DIV, S_B_DW, S_B_DWW, S_B_DH, S_B_DHW,
    S_B_W, S_B_WW, S_B_H, S_B_HW, S_POST, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    POST_ID, POST_INV, POST_HALF, POST_INV_HALF, POST_HALF_INV, POST_HALF_ADD
  } post_e;

  typedef enum logic [1:0] {
    RET_CURVE, RET_B_FIRST, RET_B_SEG
  } ret_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [WW-1:0] sin_coef(input logic [2:0] idx);
    logic [WW-1:0] c;
    case (idx)
      3'd0: c = SC9;
      3'd1: c = SC7;
      3'd2: c = SC5;
      3'd3: c = SC3;
      3'd4: c = SC1;
      default: c = SC1;
    endcase
    return c;
  endfunction

endpackage

// ----- src/ece_mul.sv -----
// Shared Q30 multiplier with round-half-up and a registered product.
module ece_mul (
  input  logic                 clk_i,
  input  logic [ece_pkg::WW-1:0] a_i,
  input  logic [ece_pkg::WW-1:0] b_i,
  output logic [ece_pkg::WW-1:0] p_o
);
  import ece_pkg::*;

  logic [2*WW-1:0] prod;
  logic [2*WW-1:0] rnd;
  logic [WW-1:0]   p_q;

  assign prod = {{WW{1'b0}}, a_i} * {{WW{1'b0}}, b_i};
  assign rnd  = prod + {{WW{1'b0}}, HALF_W};

  always_ff @(posedge clk_i) begin
    p_q <= rnd[WORK_BITS +: WW];
  end

  assign p_o = p_q;
endmodule

// ----- src/ece_div.sv -----
// Restoring divider, one quotient bit per cycle, for (num << 30) / den.
module ece_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ece_pkg::WW-1:0]    num_i,
  input  logic [ece_pkg::WW-1:0]    den_i,
  output ece_pkg::div_stat_t        stat_o,
  output logic [ece_pkg::QUO_W-1:0] quo_o
);
  import ece_pkg::*;

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [WW-1:0]     den_q;
  logic [QUO_W-1:0]  quo_q;
  logic              bit_d;
  logic [REM_W-1:0]  den_x;

  assign den_x = REM_W'(den_q);
  assign bit_d = rem_q >= den_x;
  assign rem_d = bit_d ? rem_q - den_x : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= REM_W'(num_i);
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_d[REM_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], bit_d};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
endmodule

// ----- src/easing_curve_evaluator_top.sv -----
// Top level of the easing curve evaluator: configuration, sequencer and output stage.
// One request at a time. The work per request is set by the one shared multiplier, whose
// product is registered (seven products per sine), and by the bit-serial divider used for
// the segment position. The input stalls from acceptance until the result is loaded into
// the output register, and a new request is taken while that result still waits
// downstream.
module easing_curve_evaluator_top #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [FRAC_BITS:0]                 progress_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [FRAC_BITS:0]                 eased_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ece_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [FRAC_BITS+1:0]               cfg_data_i
);
  import ece_pkg::*;

  localparam int PW        = FRAC_BITS + 1;
  localparam int CW        = FRAC_BITS + 2;
  localparam int SHIFT_OUT = WORK_BITS - FRAC_BITS;
  localparam int CNT_W     = ($clog2(MAX_ORDER + 1) > 3) ? $clog2(MAX_ORDER + 1) : 3;
  localparam logic [PW-1:0] ONE_F     = PW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] SCALE_MAX = CW'(2) << FRAC_BITS;
  localparam logic [WW-1:0] RND       = WW'((64'd1 << SHIFT_OUT) >> 1);

  // Configuration registers.
  logic [1:0]           kind_q, mode_q;
  logic [4:0]           order_q;
  logic [FRAC_BITS-1:0] wdec_q, hdec_q;
  logic [CW-1:0]        bscale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_LINEAR;
      mode_q   <= MODE_IN;
      order_q  <= 5'd1;
      wdec_q   <= '0;
      hdec_q   <= '0;
      bscale_q <= SCALE_MAX;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CURVE_KIND:   kind_q  <= cfg_data_i[1:0];
        CFG_EASE_MODE:    mode_q  <= cfg_data_i[1:0];
        CFG_CURVE_ORDER:  order_q <= cfg_data_i[4:0];
        CFG_WIDTH_DECAY:  wdec_q  <= cfg_data_i[FRAC_BITS-1:0];
        CFG_HEIGHT_DECAY: hdec_q  <= cfg_data_i[FRAC_BITS-1:0];
        CFG_BOUNCE_SCALE: bscale_q <= (cfg_data_i > SCALE_MAX) ? SCALE_MAX : cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (order_q == 5'd0) begin
      n_eff = CNT_W'(1);
    end else if (int'(order_q) > MAX_ORDER) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else begin
      n_eff = CNT_W'(order_q);
    end
  end

  logic [WW-1:0] dw_w, dh_w, s_w, first_w;
  assign dw_w    = WW'(wdec_q) << SHIFT_OUT;
  assign dh_w    = WW'(hdec_q) << SHIFT_OUT;
  assign s_w     = WW'(bscale_q) << SHIFT_OUT;
  assign first_w = s_w >> 1;

  // Sequencer and datapath registers.
  state_e           state_q, state_d;
  logic [WW-1:0]    t_q, t_d, x_q, x_d, y_q, y_d, x2_q, x2_d, sx_q, sx_d;
  logic [WW-1:0]    dwp_q, dwp_d, dhp_q, dhp_d, v_q, v_d;
  logic [CUR_W-1:0] prev_q, prev_d, cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  post_e            post_q, post_d;
  ret_e             ret_q, ret_d;
  logic             out_vld_q, out_vld_d;
  logic [PW-1:0]    out_val_q, out_val_d;

  logic [WW-1:0]    mul_a, mul_b, mul_p;
  logic             div_start;
  logic [WW-1:0]    div_num, div_den;
  div_stat_t        div_stat;
  logic [QUO_W-1:0] div_quo;

  ece_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ece_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  logic             in_acc, out_free;
  logic [PW-1:0]    prog_sat;
  logic [WW-1:0]    t2, sin_res;
  logic             t_low, in_first, hit;
  logic [CUR_W-1:0] cur_next;
  logic [CNT_W-1:0] cnt_inc;
  state_e           prep_next;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign prog_sat = (progress_i > ONE_F) ? ONE_F : progress_i;
  assign t2       = t_q << 1;
  assign t_low    = t_q < HALF_W;
  assign sin_res  = (mul_p > ONE_W) ? ONE_W : mul_p;
  assign in_first = x_q <= first_w;
  assign cur_next = cur_q + CUR_W'(mul_p);
  assign hit      = (CUR_W'(x_q) >= prev_q) && (CUR_W'(x_q) < cur_next);
  assign cnt_inc  = cnt_q + 1'b1;

  always_comb begin
    if (mode_q != MODE_IN && mode_q != MODE_OUT && mode_q != MODE_INOUT) begin
      prep_next = S_POST;
    end else begin
      case (kind_q)
        KIND_SINE:   prep_next = S_SIN_X2;
        KIND_POLY:   prep_next = S_POW_M;
        KIND_BOUNCE: prep_next = S_B_INIT;
        default:     prep_next = S_POST;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_PREP;
      S_PREP:    state_d = prep_next;
      S_SIN_X2:  state_d = S_SIN_X2W;
      S_SIN_X2W: state_d = S_SIN_M;
      S_SIN_M:   state_d = S_SIN_MW;
      S_SIN_MW:  state_d = (cnt_q[2:0] == SIN_LAST) ? S_SIN_F : S_SIN_M;
      S_SIN_F:   state_d = S_SIN_FW;
      S_SIN_FW:  state_d = (ret_q == RET_B_SEG) ? S_B_H : S_POST;
      S_POW_M:   state_d = S_POW_W;
      S_POW_W:   state_d = (cnt_inc == n_eff) ? S_POST : S_POW_M;
      S_B_INIT: begin
        if (in_first) begin
          state_d = (first_w == '0) ? S_SIN_X2 : S_B_DIV;
        end else begin
          state_d = (CNT_W'(1) < n_eff) ? S_B_DW : S_POST;
        end
      end
      S_B_DIV:   if (div_stat.done) state_d = S_SIN_X2;
      S_B_DW:    state_d = S_B_DWW;
      S_B_DWW:   state_d = S_B_DH;
      S_B_DH:    state_d = S_B_DHW;
      S_B_DHW:   state_d = S_B_W;
      S_B_W:     state_d = S_B_WW;
      S_B_WW: begin
        if (hit) begin
          state_d = S_B_DIV;
        end else begin
          state_d = (cnt_inc < n_eff) ? S_B_DW : S_POST;
        end
      end
      S_B_H:     state_d = S_B_HW;
      S_B_HW:    state_d = S_POST;
      S_POST:    state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath and unit control.
  logic [WW:0]   r2;
  logic [WW-1:0] r_seg, r_first, v_sat, v_rnd;
  assign r2      = {1'b0, div_quo, 1'b0} >> (QUO_W + 2 - (WW + 1));
  assign r_first = (WW'(div_quo) > ONE_W) ? ONE_W : WW'(div_quo);
  always_comb begin
    if (r2 > (WW + 1)'(ONE_W)) begin
      r_seg = (r2 >= (WW + 1)'(TWO_W)) ? '0 : WW'((WW + 1)'(TWO_W) - r2);
    end else begin
      r_seg = r2[WW-1:0];
    end
  end
  assign v_sat = (v_q > ONE_W) ? ONE_W : v_q;
  assign v_rnd = (v_sat + RND) >> SHIFT_OUT;

  always_comb begin
    t_d = t_q; x_d = x_q; y_d = y_q; x2_d = x2_q; sx_d = sx_q;
    dwp_d = dwp_q; dhp_d = dhp_q; v_d = v_q; prev_d = prev_q; cur_d = cur_q;
    cnt_d = cnt_q; post_d = post_q; ret_d = ret_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_val_d = out_val_q;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) t_d = WW'(prog_sat) << SHIFT_OUT;
      S_PREP: begin
        y_d = t_q; post_d = POST_ID; ret_d = RET_CURVE; cnt_d = '0;
        x_d = t_q;
        if (kind_q == KIND_SINE) begin
          case (mode_q)
            MODE_IN:  begin x_d = ONE_W - t_q; post_d = POST_INV; end
            MODE_OUT: x_d = t_q;
            default: begin
              if (t_low) begin
                x_d = ONE_W - t2; post_d = POST_HALF_INV;
              end else begin
                x_d = t2 - ONE_W; post_d = POST_HALF_ADD;
              end
            end
          endcase
          sx_d = x_d;
        end else begin
          case (mode_q)
            MODE_IN: begin
              x_d    = (kind_q == KIND_POLY) ? t_q : ONE_W - t_q;
              post_d = (kind_q == KIND_POLY) ? POST_ID : POST_INV;
            end
            MODE_OUT: begin
              x_d    = (kind_q == KIND_POLY) ? ONE_W - t_q : t_q;
              post_d = (kind_q == KIND_POLY) ? POST_INV : POST_ID;
            end
            default: begin
              if (t_low) begin
                x_d = t2; post_d = POST_HALF;
              end else begin
                x_d = TWO_W - t2; post_d = POST_INV_HALF;
              end
            end
          endcase
          if (kind_q == KIND_POLY) y_d = ONE_W;
        end
        // Linear and the undefined mode pass the progress straight through.
        if (prep_next == S_POST) begin
          post_d = POST_ID;
          y_d    = t_q;
        end
      end
      S_SIN_X2: begin mul_a = sx_q; mul_b = sx_q; end
      S_SIN_X2W: begin x2_d = mul_p; y_d = SC11; cnt_d = '0; end
      S_SIN_M: begin mul_a = y_q; mul_b = x2_q; end
      S_SIN_MW: begin y_d = sin_coef(cnt_q[2:0]) - mul_p; cnt_d = cnt_inc; end
      S_SIN_F: begin mul_a = y_q; mul_b = sx_q; end
      S_SIN_FW: y_d = (ret_q == RET_B_FIRST) ? ONE_W - sin_res : sin_res;
      S_POW_M: begin mul_a = y_q; mul_b = x_q; end
      S_POW_W: begin y_d = mul_p; cnt_d = cnt_inc; end
      S_B_INIT: begin
        if (in_first) begin
          ret_d = RET_B_FIRST;
          sx_d  = ONE_W;
          if (first_w != '0) begin
            div_start = 1'b1; div_num = x_q; div_den = first_w;
          end
        end else begin
          prev_d = CUR_W'(first_w); cur_d = CUR_W'(first_w);
          dwp_d = ONE_W; dhp_d = ONE_W; cnt_d = CNT_W'(1);
          y_d = ONE_W;
        end
      end
      S_B_DIV: begin
        if (div_stat.done) begin
          sx_d = (ret_q == RET_B_FIRST) ? ONE_W - r_first : r_seg;
        end
      end
      S_B_DW:  begin mul_a = dwp_q; mul_b = dw_w; end
      S_B_DWW: dwp_d = mul_p;
      S_B_DH:  begin mul_a = dhp_q; mul_b = dh_w; end
      S_B_DHW: dhp_d = mul_p;
      S_B_W:   begin mul_a = dwp_q; mul_b = s_w; end
      S_B_WW: begin
        cur_d = cur_next;
        if (hit) begin
          ret_d = RET_B_SEG;
          div_start = 1'b1;
          div_num = x_q - prev_q[WW-1:0];
          div_den = mul_p;
        end else begin
          prev_d = cur_next;
          cnt_d  = cnt_inc;
          y_d    = ONE_W;
        end
      end
      S_B_H:  begin mul_a = y_q; mul_b = dhp_q; end
      S_B_HW: y_d = ONE_W - mul_p;
      S_POST: begin
        case (post_q)
          POST_INV:      v_d = ONE_W - y_q;
          POST_HALF:     v_d = y_q >> 1;
          POST_INV_HALF: v_d = ONE_W - (y_q >> 1);
          POST_HALF_INV: v_d = (ONE_W - y_q) >> 1;
          POST_HALF_ADD: v_d = (ONE_W + y_q) >> 1;
          default:       v_d = y_q;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_val_d = (v_rnd > WW'(ONE_F)) ? ONE_F : v_rnd[PW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; x_q <= x_d; y_q <= y_d; x2_q <= x2_d; sx_q <= sx_d;
    dwp_q <= dwp_d; dhp_q <= dhp_d; v_q <= v_d; prev_q <= prev_d; cur_q <= cur_d;
    cnt_q <= cnt_d; post_q <= post_d; ret_q <= ret_d; out_val_q <= out_val_d;
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_vld_q;
  assign eased_value_o = out_val_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_PREP)
    else $error("accepted request did not start the sequencer");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> eased_value_o <= ONE_F)
    else $error("eased value above one");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_B_DIV |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

endmodule
